/* rtl/acdq_pkg.sv */
// shared types and constants for the actuator command limit and delay queue
`default_nettype none
package acdq_pkg;

   localparam int TORQUE_W = 24;
   localparam int LIMIT_W  = 23;
   localparam int CAP_W    = 24;
   localparam int STEP_W   = 32;
   localparam int TIME_W   = 44;
   localparam int CSR_W    = 32;
   localparam int MAX_OUT  = 16;
   localparam int NOUT_W   = 5;
   localparam int ITER_W   = 5;
   localparam int ROOT_ITERS = 24;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_STEP  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_DELAY   = 3'd0,
      CSR_MAX_X   = 3'd1,
      CSR_MAX_Y   = 3'd2,
      CSR_MAX_Z   = 3'd3,
      CSR_MAX_MAG = 3'd4
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_APPLIED = 1'b0,
      KIND_DROPPED = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_CMP, ST_ROOT, ST_MUL, ST_DIV, ST_STORE,
      ST_READ, ST_CHECK, ST_LAST
   } state_type;

   typedef struct packed {
      logic signed [TORQUE_W-1:0] x;
      logic signed [TORQUE_W-1:0] y;
      logic signed [TORQUE_W-1:0] z;
      logic [TIME_W-1:0]          issue;
   } entry_type;

   typedef struct packed {
      logic                       result_kind;
      logic signed [TORQUE_W-1:0] applied_x;
      logic signed [TORQUE_W-1:0] applied_y;
      logic signed [TORQUE_W-1:0] applied_z;
      logic [STEP_W-1:0]          apply_duration;
      logic [TIME_W-1:0]          exec_time;
      logic                       last;
   } rsp_type;

   function automatic logic [TORQUE_W-1:0] abs24(input logic signed [TORQUE_W-1:0] v);
      abs24 = v[TORQUE_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage
`default_nettype wire

/* rtl/acdq_req_if.sv */
// request channel: command, step or clear beats
`default_nettype none
interface acdq_req_if;
   import acdq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 opcode;
   logic signed [TORQUE_W-1:0] torque_x;
   logic signed [TORQUE_W-1:0] torque_y;
   logic signed [TORQUE_W-1:0] torque_z;
   logic [STEP_W-1:0]          time_step;
   modport source (output valid, opcode, torque_x, torque_y, torque_z, time_step,
                   input ready);
   modport sink (input valid, opcode, torque_x, torque_y, torque_z, time_step,
                 output ready);
endinterface
`default_nettype wire

/* rtl/acdq_rsp_if.sv */
// response channel: applied or dropped command beats
`default_nettype none
interface acdq_rsp_if;
   import acdq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       result_kind;
   logic signed [TORQUE_W-1:0] applied_x;
   logic signed [TORQUE_W-1:0] applied_y;
   logic signed [TORQUE_W-1:0] applied_z;
   logic [STEP_W-1:0]          apply_duration;
   logic [TIME_W-1:0]          exec_time;
   logic                       last;
   modport source (output valid, result_kind, applied_x, applied_y, applied_z,
                   apply_duration, exec_time, last, input ready);
   modport sink (input valid, result_kind, applied_x, applied_y, applied_z,
                 apply_duration, exec_time, last, output ready);
endinterface
`default_nettype wire

/* rtl/actuator_command_limit_delay_queue.sv */
// Torque command limiter with a transport-delay queue. A send beat clamps
// each axis and, when a nonzero cap is set and exceeded, caps the vector
// magnitude with a bit-serial square root and three restoring divisions.
// A step beat releases up to 16 due commands, each read through the
// registered queue memory port, and a clear beat empties the queue and
// resets time. One beat is worked on at a time; a finished result waits
// in the output register while the next request is accepted. There is no
// clearing pass after reset.
`default_nettype none
module actuator_command_limit_delay_queue
   import acdq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   acdq_req_if.sink               req_bus,
   acdq_rsp_if.source             rsp_bus,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // configuration
   logic [STEP_W-1:0]  delay_ff;
   logic [LIMIT_W-1:0] max_x_ff, max_y_ff, max_z_ff;
   logic [CAP_W-1:0]   cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         max_x_ff <= '0;
         max_y_ff <= '0;
         max_z_ff <= '0;
         cap_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY:   delay_ff <= csr_wdata;
            CSR_MAX_X:   max_x_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_MAX_Y:   max_y_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_MAX_Z:   max_z_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_MAX_MAG: cap_ff   <= csr_wdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic signed [TORQUE_W-1:0] clamp(
      input logic signed [TORQUE_W-1:0] v, input logic [LIMIT_W-1:0] lim);
      logic signed [TORQUE_W:0] l;
      logic signed [TORQUE_W:0] w;
      l = $signed({2'b00, lim});
      w = $signed({v[TORQUE_W-1], v});
      if (lim == '0)    clamp = v;
      else if (w > l)   clamp = l[TORQUE_W-1:0];
      else if (w < -l)  clamp = TORQUE_W'(-l);
      else              clamp = v;
   endfunction

   // control and datapath registers
   state_type state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [1:0] axis_ff, axis_in;
   logic [NOUT_W-1:0] nout_ff, nout_in;
   logic pend_ff, pend_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic signed [TORQUE_W-1:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [47:0] ss_ff, ss_in;
   logic [25:0] rem_ff, rem_in;
   logic [CAP_W-1:0] root_ff, root_in;
   logic [47:0] num_ff, num_in;
   rsp_type pend_rsp_ff, pend_rsp_in;
   rsp_type out_ff;
   logic out_valid_ff;

   // queue memory
   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;
   logic      wr_en;
   entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[tail_ff] <= wr_data;
      rd_ff <= mem[head_ff];
   end

   logic push_en;
   rsp_type push_data;
   wire out_free = !out_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (push_en) out_valid_ff <= 1'b1;
      else if (rsp_bus.ready) out_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (push_en) out_ff <= push_data;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.result_kind    = out_ff.result_kind;
   assign rsp_bus.applied_x      = out_ff.applied_x;
   assign rsp_bus.applied_y      = out_ff.applied_y;
   assign rsp_bus.applied_z      = out_ff.applied_z;
   assign rsp_bus.apply_duration = out_ff.apply_duration;
   assign rsp_bus.exec_time      = out_ff.exec_time;
   assign rsp_bus.last           = out_ff.last;

   assign req_bus.ready = (state_ff == ST_IDLE);
   wire req_fire = req_bus.valid && req_bus.ready;

   // selected axis for the squaring and scaling steps
   logic signed [TORQUE_W-1:0] axis_v;
   always_comb begin
      case (axis_ff)
         2'd0:    axis_v = vx_ff;
         2'd1:    axis_v = vy_ff;
         default: axis_v = vz_ff;
      endcase
   end
   wire [TORQUE_W-1:0] axis_mag = abs24(axis_v);

   // time arithmetic
   logic [TIME_W:0] sum_time, ex_full, ct_plus1, ct_delay;
   logic [TIME_W-1:0] sat_ex, diff_t;
   logic [STEP_W-1:0] eff;

   always_comb begin
      sum_time = {1'b0, time_ff} + (TIME_W+1)'(req_bus.time_step);
      ex_full  = {1'b0, rd_ff.issue} + (TIME_W+1)'(delay_ff);
      ct_plus1 = {1'b0, time_ff} + (TIME_W+1)'(1);
      ct_delay = {1'b0, time_ff} + (TIME_W+1)'(delay_ff);
      sat_ex   = ex_full[TIME_W] ? TIME_MAX : ex_full[TIME_W-1:0];
      diff_t   = time_ff - ex_full[TIME_W-1:0];
      if ({1'b0, time_ff} > ex_full) begin
         eff = (diff_t < TIME_W'(step_ff)) ? diff_t[STEP_W-1:0] : step_ff;
      end else begin
         eff = step_ff;
      end
      if (eff == '0) eff = STEP_W'(1);
   end

   // sqrt and divide steps
   logic [25:0] rad_rem, trial;
   logic [24:0] div_r;
   logic [24:0] div_sub;
   logic        div_bit;
   logic [TORQUE_W-1:0] qv;
   always_comb begin
      rad_rem = {rem_ff[23:0], ss_ff[47:46]};
      trial   = {root_ff, 2'b01};
      div_r   = {num_ff[47:24], num_ff[23]};
      div_bit = (div_r >= {1'b0, root_ff});
      div_sub = div_bit ? (div_r - {1'b0, root_ff}) : div_r;
      qv      = {num_ff[22:0], div_bit};
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      time_in     = time_ff;
      iter_in     = iter_ff;
      axis_in     = axis_ff;
      nout_in     = nout_ff;
      pend_in     = pend_ff;
      step_in     = step_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      vz_in       = vz_ff;
      ss_in       = ss_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      num_in      = num_ff;
      pend_rsp_in = pend_rsp_ff;
      wr_en       = 1'b0;
      wr_data     = '{x: vx_ff, y: vy_ff, z: vz_ff, issue: time_ff};
      push_en     = 1'b0;
      push_data   = pend_rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (opcode_type'(req_bus.opcode))
                  OP_SEND: begin
                     vx_in   = clamp(req_bus.torque_x, max_x_ff);
                     vy_in   = clamp(req_bus.torque_y, max_y_ff);
                     vz_in   = clamp(req_bus.torque_z, max_z_ff);
                     ss_in   = '0;
                     axis_in = 2'd0;
                     state_in = (cap_ff == '0) ? ST_STORE : ST_SQ;
                  end
                  OP_STEP: begin
                     time_in  = sum_time[TIME_W] ? TIME_MAX : sum_time[TIME_W-1:0];
                     step_in  = req_bus.time_step;
                     nout_in  = '0;
                     pend_in  = 1'b0;
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                     time_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SQ: begin
            ss_in = ss_ff + 48'(axis_mag * axis_mag);
            if (axis_ff == 2'd2) state_in = ST_CMP;
            else axis_in = axis_ff + 2'd1;
         end
         ST_CMP: begin
            if (ss_ff > 48'(cap_ff * cap_ff)) begin
               rem_in   = '0;
               root_in  = '0;
               iter_in  = '0;
               state_in = ST_ROOT;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_ROOT: begin
            ss_in = {ss_ff[45:0], 2'b00};
            if (rad_rem >= trial) begin
               rem_in  = rad_rem - trial;
               root_in = {root_ff[CAP_W-2:0], 1'b1};
            end else begin
               rem_in  = rad_rem;
               root_in = {root_ff[CAP_W-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(ROOT_ITERS - 1)) begin
               axis_in  = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            num_in   = 48'(axis_mag * cap_ff);
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, remainder in the upper half, quotient shifts in below
            num_in = {div_sub[TORQUE_W-1:0], qv};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(TORQUE_W - 1)) begin
               case (axis_ff)
                  2'd0:    vx_in = vx_ff[TORQUE_W-1] ? (~qv + 1'b1) : qv;
                  2'd1:    vy_in = vy_ff[TORQUE_W-1] ? (~qv + 1'b1) : qv;
                  default: vz_in = vz_ff[TORQUE_W-1] ? (~qv + 1'b1) : qv;
               endcase
               if (axis_ff == 2'd2) state_in = ST_STORE;
               else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_STORE: begin
            if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
               push_data = '{result_kind: KIND_DROPPED, applied_x: vx_ff,
                             applied_y: vy_ff, applied_z: vz_ff,
                             apply_duration: '0,
                             exec_time: ct_delay[TIME_W] ? TIME_MAX
                                                         : ct_delay[TIME_W-1:0],
                             last: 1'b1};
               if (out_free) begin
                  push_en  = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               wr_en    = 1'b1;
               tail_in  = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            // head entry read lands in rd_ff on the next cycle
            state_in = (count_ff == '0) ? ST_LAST : ST_CHECK;
         end
         ST_CHECK: begin
            if (ex_full > ct_plus1) begin
               state_in = ST_LAST;
            end else if (!pend_ff || out_free) begin
               push_en     = pend_ff;
               push_data.last = 1'b0;
               pend_in     = 1'b1;
               pend_rsp_in = '{result_kind: KIND_APPLIED, applied_x: rd_ff.x,
                               applied_y: rd_ff.y, applied_z: rd_ff.z,
                               apply_duration: eff, exec_time: sat_ex, last: 1'b1};
               head_in  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               nout_in  = nout_ff + 1'b1;
               state_in = (nout_ff == NOUT_W'(MAX_OUT - 1)) ? ST_LAST : ST_READ;
            end
         end
         ST_LAST: begin
            push_data.last = 1'b1;
            if (!pend_ff) state_in = ST_IDLE;
            else if (out_free) begin
               push_en  = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         time_ff  <= '0;
         iter_ff  <= '0;
         axis_ff  <= '0;
         nout_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         time_ff  <= time_in;
         iter_ff  <= iter_in;
         axis_ff  <= axis_in;
         nout_ff  <= nout_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      vz_ff       <= vz_in;
      ss_ff       <= ss_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      num_ff      <= num_in;
      pend_rsp_ff <= pend_rsp_in;
   end

endmodule
`default_nettype wire
